/* src/i2crm_pkg.sv */
`default_nettype none

package i2crm_pkg;

  // command codes on the input word
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SETMODE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_REGISTER  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_REGISTER  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TICKS  = 4'd3;

  localparam logic [7:0] QUARTER_TICKS_RST = 8'd8;

  typedef struct packed {
    logic [1:0] cmd;
    logic       mode_enable;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       failed;
    logic [7:0] sensor_byte;
  } out_t;

  // classified tick word passed from front to back
  typedef struct packed {
    logic start;
    logic kind;   // 1 read, 0 set mode
    logic mode;
    logic sda;
  } item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] mode_register;
    logic [7:0] data_register;
    logic [7:0] quarter_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* src/i2crm_front.sv */
`default_nettype none

module i2crm_front (
  input  wire  i2crm_pkg::in_t   in_data_i,
  output i2crm_pkg::item_t       item_o
);

  // codes other than set mode or read are plain ticks
  always_comb begin
    item_o.start = (in_data_i.cmd == i2crm_pkg::CMD_SETMODE) ||
                   (in_data_i.cmd == i2crm_pkg::CMD_READ);
    item_o.kind  = (in_data_i.cmd == i2crm_pkg::CMD_READ);
    item_o.mode  = in_data_i.mode_enable;
    item_o.sda   = in_data_i.sda_in;
  end

endmodule

`default_nettype wire

/* src/i2crm_queue.sv */
`default_nettype none

module i2crm_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_valid_i,
  output logic                   push_ready_o,
  input  wire  i2crm_pkg::item_t push_data_i,
  output logic                   pop_valid_o,
  input  wire                    pop_ready_i,
  output i2crm_pkg::item_t       pop_data_o
);

  i2crm_pkg::item_t data_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = data_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* src/i2crm_back.sv */
`default_nettype none

module i2crm_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire  i2crm_pkg::cfg_t  cfg_i,
  input  wire                    item_valid_i,
  output logic                   item_ready_o,
  input  wire  i2crm_pkg::item_t item_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output i2crm_pkg::out_t        out_data_o
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_S0   = 4'd1;
  localparam logic [3:0] PH_S1   = 4'd2;
  localparam logic [3:0] PH_S2   = 4'd3;
  localparam logic [3:0] PH_WLO  = 4'd4;
  localparam logic [3:0] PH_WHI  = 4'd5;
  localparam logic [3:0] PH_ALO  = 4'd6;
  localparam logic [3:0] PH_AHI  = 4'd7;
  localparam logic [3:0] PH_RHI  = 4'd8;
  localparam logic [3:0] PH_RLO  = 4'd9;
  localparam logic [3:0] PH_NLO  = 4'd10;
  localparam logic [3:0] PH_NHI  = 4'd11;
  localparam logic [3:0] PH_P0   = 4'd12;
  localparam logic [3:0] PH_P1   = 4'd13;
  localparam logic [3:0] PH_P2   = 4'd14;

  logic [3:0] phase_q, phase_d;
  logic       kind_q, kind_d;
  logic [1:0] byte_q, byte_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] delay_q, delay_d;
  logic       held_q, held_d;
  logic       err_q, err_d;
  logic [7:0] last_q, last_d;

  logic            out_valid_q;
  i2crm_pkg::out_t out_q, out_d;
  logic            load;
  logic [7:0]      qm1;

  function automatic logic [7:0] byte_to_send(input logic [1:0] idx, input logic kind,
                                              input i2crm_pkg::cfg_t cfg, input logic held);
    logic [7:0] addr;
    begin
      addr = {cfg.device_address, 1'b0};
      if (idx == 2'd0) begin
        byte_to_send = addr;
      end else if (idx == 2'd1) begin
        byte_to_send = kind ? cfg.data_register : cfg.mode_register;
      end else begin
        byte_to_send = kind ? (addr | 8'h01) : {7'd0, held};
      end
    end
  endfunction

  assign qm1          = (cfg_i.quarter_ticks == 8'd0) ? 8'd0 : (cfg_i.quarter_ticks - 8'd1);
  assign item_ready_o = !out_valid_q || out_ready_i;
  assign load         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  always_comb begin
    logic scl, sda, busy, done, fail;
    phase_d = phase_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    delay_d = delay_q;
    held_d  = held_q;
    err_d   = err_q;
    last_d  = last_q;
    scl  = 1'b1;
    sda  = 1'b1;
    busy = 1'b0;
    done = 1'b0;
    fail = 1'b0;

    if (phase_d == PH_IDLE && item_i.start) begin
      kind_d  = item_i.kind;
      held_d  = item_i.mode;
      byte_d  = 2'd0;
      bit_d   = 4'd0;
      shift_d = 8'd0;
      err_d   = 1'b0;
      phase_d = PH_S0;
      delay_d = qm1;
    end

    if (phase_d != PH_IDLE) begin
      busy = 1'b1;
      unique case (phase_d)
        PH_S1:                  begin scl = 1'b1; sda = 1'b0;       end
        PH_S2, PH_P0:           begin scl = 1'b0; sda = 1'b0;       end
        PH_WLO:                 begin scl = 1'b0; sda = shift_d[7]; end
        PH_WHI:                 begin scl = 1'b1; sda = shift_d[7]; end
        PH_ALO, PH_RLO, PH_NLO: begin scl = 1'b0; sda = 1'b1;       end
        PH_P1:                  begin scl = 1'b1; sda = 1'b0;       end
        default:                begin scl = 1'b1; sda = 1'b1;       end
      endcase

      if (delay_d != 8'd0) begin
        delay_d = delay_d - 8'd1;
      end else begin
        delay_d = qm1;
        unique case (phase_d)
          PH_S0: phase_d = PH_S1;
          PH_S1: phase_d = PH_S2;
          PH_S2: begin
            shift_d = byte_to_send(byte_d, kind_d, cfg_i, held_d);
            bit_d   = 4'd0;
            phase_d = PH_WLO;
          end
          PH_WLO: phase_d = PH_WHI;
          PH_WHI: begin
            shift_d = {shift_d[6:0], 1'b0};
            bit_d   = bit_d + 4'd1;
            phase_d = bit_d[3] ? PH_ALO : PH_WLO;
          end
          PH_ALO: phase_d = PH_AHI;
          PH_AHI: begin
            // no ACK: straight to STOP
            if (item_i.sda) begin
              err_d   = 1'b1;
              phase_d = PH_P0;
            end else if (byte_d[1]) begin
              if (kind_d) begin
                shift_d = 8'd0;
                bit_d   = 4'd0;
                phase_d = PH_RHI;
              end else begin
                phase_d = PH_P0;
              end
            end else if (byte_d == 2'd1 && kind_d) begin
              // repeated START before the address with read bit
              byte_d  = 2'd2;
              phase_d = PH_S0;
            end else begin
              byte_d  = byte_d + 2'd1;
              shift_d = byte_to_send(byte_d, kind_d, cfg_i, held_d);
              bit_d   = 4'd0;
              phase_d = PH_WLO;
            end
          end
          PH_RHI: begin
            shift_d = {shift_d[6:0], item_i.sda};
            phase_d = PH_RLO;
          end
          PH_RLO: begin
            bit_d   = bit_d + 4'd1;
            phase_d = bit_d[3] ? PH_NLO : PH_RHI;
          end
          PH_NLO: phase_d = PH_NHI;
          PH_NHI: phase_d = PH_P0;
          PH_P0:  phase_d = PH_P1;
          PH_P1:  phase_d = PH_P2;
          default: begin
            if (!err_d && kind_d) begin
              last_d = shift_d;
            end
            busy    = 1'b0;
            done    = 1'b1;
            fail    = err_d;
            phase_d = PH_IDLE;
            delay_d = 8'd0;
          end
        endcase
      end
    end

    out_d.scl_level   = scl;
    out_d.sda_level   = sda;
    out_d.busy_res    = busy;
    out_d.done_res    = done;
    out_d.failed      = fail;
    out_d.sensor_byte = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kind_q      <= 1'b0;
      byte_q      <= 2'd0;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      delay_q     <= 8'd0;
      held_q      <= 1'b0;
      err_q       <= 1'b0;
      last_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        byte_q  <= byte_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        delay_q <= delay_d;
        held_q  <= held_d;
        err_q   <= err_d;
        last_q  <= last_d;
      end
      if (item_ready_o) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_fail_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_d.failed |-> out_d.done_res)
    else $error("failure flagged without done");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_d.done_res |=> phase_q == PH_IDLE)
    else $error("sequencer not idle after done");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> bit_q <= 4'd8)
    else $error("bit counter out of range");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && phase_q == PH_IDLE && !item_i.start
    |=> out_q.scl_level && out_q.sda_level && !out_q.busy_res && !out_q.done_res)
    else $error("bus not released while idle");
`endif

endmodule

`default_nettype wire

/* src/i2c_register_master_core.sv */
// Channel | Dir | Handshake               | Word
// in      | in  | in_valid_i / in_ready_o | in_data_i   (cmd, mode_enable, sda_in)
// out     | out | out_valid_o/out_ready_i | out_data_o  (pins, busy, done, failed, byte)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One input word is one bus tick and yields exactly one output word.
// Sustained rate is one word per cycle while the output is not stalled; a word
// is registered in the classify stage's two-entry queue and then in the
// sequencer's output register. The sequencer steps once per accepted word.
// Either side may stall independently; the queue absorbs input while the
// output register waits. Reset clears the sequencer, queue and registers
// (quarter_ticks comes up as 8). Config writes are always accepted.
`default_nettype none

module i2c_register_master_core (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  i2crm_pkg::in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output i2crm_pkg::out_t                      out_data_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [i2crm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [7:0]                           cfg_data_i
);

  i2crm_pkg::cfg_t  cfg_q;
  i2crm_pkg::item_t front_item;
  i2crm_pkg::item_t q_item;
  logic             q_valid;
  logic             q_ready;

  assign cfg_ready_o = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= 7'd0;
      cfg_q.mode_register  <= 8'd0;
      cfg_q.data_register  <= 8'd0;
      cfg_q.quarter_ticks  <= i2crm_pkg::QUARTER_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        i2crm_pkg::CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data_i[6:0];
        i2crm_pkg::CFG_MODE_REGISTER:  cfg_q.mode_register  <= cfg_data_i;
        i2crm_pkg::CFG_DATA_REGISTER:  cfg_q.data_register  <= cfg_data_i;
        i2crm_pkg::CFG_QUARTER_TICKS:  cfg_q.quarter_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: decode the command
  i2crm_front u_front (
    .in_data_i (in_data_i),
    .item_o    (front_item)
  );

  // short queue between front and sequencer
  i2crm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_item)
  );

  // back: bus sequencer with registered output word
  i2crm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
